// ===== src/steq_pkg.sv =====
// Types and codes shared by the sorted timeout event queue.
// No dependencies.
package steq_pkg;

  localparam logic [2:0] F_ALLOC = 3'd0;
  localparam logic [2:0] F_REL   = 3'd1;
  localparam logic [2:0] F_WAKE  = 3'd2;
  localparam logic [2:0] F_CLEAN = 3'd3;
  localparam logic [2:0] F_TICK  = 3'd4;

  localparam logic [2:0] K_ALLOC       = 3'd0;
  localparam logic [2:0] K_FULL        = 3'd1;
  localparam logic [2:0] K_REL_OK      = 3'd2;
  localparam logic [2:0] K_REL_TIMEOUT = 3'd3;
  localparam logic [2:0] K_WOKEN       = 3'd4;
  localparam logic [2:0] K_EXPIRED     = 3'd5;
  localparam logic [2:0] K_CLEANED     = 3'd6;
  localparam logic [2:0] K_NONE        = 3'd7;

  localparam logic [5:0] MAX_RESULTS = 6'd32;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] thread_id;
    logic [63:0] channel;
    logic [63:0] wake_time;
    logic [4:0]  handle;
    logic [63:0] now_time;
  } req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  entry_index;
    logic [63:0] wake_channel;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [63:0] wake;
    logic [63:0] chan;
    logic [31:0] thread;
  } entry_t;

endpackage

// ===== src/sorted_timeout_event_queue.sv =====
// Sorted timeout event queue: entry pool, free stack and wake-time sorted list.
// Depends on steq_pkg.
//
//   channel | signals                   | moves
//   --------+---------------------------+-------------------------------
//   request | req_valid, req_ready, req | one command (steq_pkg::req_t)
//   result  | rsp_valid, rsp_ready, rsp | one result (steq_pkg::rsp_t)
//
// One request at a time. Release of an active entry, wake, cleanup and tick
// each make one pass over the sorted list, one list position per cycle through
// the order memory and then the entry memory. Allocate reads the free stack,
// writes the entry and then makes the pass. Allocate on a full pool and release
// of an inactive entry go straight to the result; an invalid release or an unknown
// code gives no result. A stalled result stalls the pass.
// Reset (synchronous) empties the list and refills the free stack at once.
module sorted_timeout_event_queue #(
  parameter int POOL_SIZE = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  steq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output steq_pkg::rsp_t rsp
);
  import steq_pkg::*;

  localparam int IW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int CW = $clog2(POOL_SIZE + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_STK   = 3'd1;
  localparam logic [2:0] S_ALLOC = 3'd2;
  localparam logic [2:0] S_PASS  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]  state;
  req_t        r;
  logic [CW-1:0] fc, min_fc, cnt, rp, wp;
  logic [POOL_SIZE-1:0] alloc_q, active_q, expired_q;
  logic        v1, v2;
  logic [IW-1:0] ord_q, idx2, carry, new_idx, stk_q;
  entry_t      ent_q;
  logic [5:0]  hits;
  logic        stopped, ins, fin_ins;
  logic        pend_v;
  rsp_t        pend, res;
  logic        out_v;
  rsp_t        out_d;

  logic [IW-1:0] order_mem [POOL_SIZE];
  entry_t        ent_mem   [POOL_SIZE];
  logic [IW-1:0] stk_mem   [POOL_SIZE];

  logic          adv, issue, done, hit, place, ow_en, push, ld, hreq_ok;
  logic [IW-1:0] ow_data, hreq, hidx, aidx;
  logic [CW-1:0] sp;
  rsp_t          newres, fin, ld_d;

  assign adv       = !out_v || rsp_ready;
  assign req_ready = (state == S_IDLE);
  assign rsp_valid = out_v;
  assign rsp       = out_d;

  assign hreq_ok = 32'(req.handle) < POOL_SIZE;
  assign hreq    = IW'(req.handle);
  assign hidx    = IW'(r.handle);
  assign issue   = rp < cnt;
  assign done    = !issue && !v1 && !v2;

  // free stack slots below the low-water mark were never written since reset
  assign sp   = fc - CW'(1);
  assign aidx = (sp < min_fc) ? IW'(CW'(POOL_SIZE - 1) - sp) : stk_q;

  always_comb begin
    hit   = 1'b0;
    place = 1'b0;
    case (r.func)
      F_WAKE:  hit = (ent_q.chan == r.channel) && (hits < MAX_RESULTS);
      F_CLEAN: hit = (ent_q.thread == r.thread_id) && (hits < MAX_RESULTS);
      F_TICK:  hit = !stopped && (hits < MAX_RESULTS) && (ent_q.wake != 64'd0)
                     && (ent_q.wake <= r.now_time);
      F_REL:   hit = (idx2 == hidx);
      F_ALLOC: place = !ins && (r.wake_time != 64'd0)
                       && ((ent_q.wake == 64'd0) || (ent_q.wake > r.wake_time));
      default: hit = 1'b0;
    endcase
  end

  always_comb begin
    newres = '0;
    newres.entry_index = 5'(idx2);
    case (r.func)
      F_WAKE: begin
        newres.kind = K_WOKEN;
        newres.wake_channel = ent_q.chan;
      end
      F_TICK: begin
        newres.kind = K_EXPIRED;
        newres.wake_channel = ent_q.chan;
      end
      default: newres.kind = K_CLEANED;
    endcase
  end

  always_comb begin
    if (r.func == F_ALLOC || r.func == F_REL) begin
      fin = res;
    end else if (pend_v) begin
      fin = pend;
    end else begin
      fin = '0;
      fin.kind = K_NONE;
    end
    fin.last = 1'b1;
  end

  // order memory write: compaction during the pass, inserted entry at the end
  always_comb begin
    ow_en   = 1'b0;
    ow_data = idx2;
    if (state == S_PASS && adv && v2 && !hit) begin
      ow_en = 1'b1;
      if (r.func == F_ALLOC) begin
        ow_data = place ? new_idx : (ins ? carry : idx2);
      end
    end else if (state == S_FIN && adv && r.func == F_ALLOC && fin_ins) begin
      ow_en   = 1'b1;
      ow_data = ins ? carry : new_idx;
    end
  end

  assign push = (state == S_FIN) && adv && (r.func == F_REL);

  always_comb begin
    ld   = 1'b0;
    ld_d = fin;
    if (state == S_PASS && adv && v2 && hit && pend_v &&
        r.func != F_REL && r.func != F_ALLOC) begin
      ld   = 1'b1;
      ld_d = pend;
    end else if (state == S_FIN && adv) begin
      ld = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ow_en) order_mem[wp[IW-1:0]] <= ow_data;
    if (adv) ord_q <= order_mem[rp[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state == S_ALLOC) ent_mem[aidx] <= '{wake: r.wake_time, chan: r.channel,
                                            thread: r.thread_id};
    if (adv) ent_q <= ent_mem[ord_q];
  end

  always_ff @(posedge clk) begin
    if (push) stk_mem[fc[IW-1:0]] <= hidx;
    stk_q <= stk_mem[sp[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ld) out_d <= ld_d;
    if (adv) idx2 <= ord_q;
    if (rst) begin
      state     <= S_IDLE;
      fc        <= CW'(POOL_SIZE);
      min_fc    <= CW'(POOL_SIZE);
      cnt       <= '0;
      alloc_q   <= '0;
      active_q  <= '0;
      expired_q <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      pend_v    <= 1'b0;
      out_v     <= 1'b0;
    end else begin
      if (ld) out_v <= 1'b1;
      else if (rsp_ready) out_v <= 1'b0;
      if (adv) begin
        v1 <= (state == S_PASS) && issue;
        v2 <= v1;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            r       <= req;
            pend_v  <= 1'b0;
            hits    <= '0;
            stopped <= 1'b0;
            ins     <= 1'b0;
            rp      <= '0;
            wp      <= '0;
            fin_ins <= 1'b0;
            case (req.func)
              F_ALLOC: begin
                if (fc == '0) begin
                  res   <= '{kind: K_FULL, entry_index: 5'd0, wake_channel: 64'd0,
                             last: 1'b1};
                  state <= S_FIN;
                end else begin
                  fin_ins <= 1'b1;
                  state   <= S_STK;
                end
              end
              F_REL: begin
                if (hreq_ok && alloc_q[hreq]) begin
                  res <= '{kind: expired_q[hreq] ? K_REL_TIMEOUT : K_REL_OK,
                           entry_index: req.handle, wake_channel: 64'd0, last: 1'b1};
                  state <= active_q[hreq] ? S_PASS : S_FIN;
                end
              end
              F_WAKE, F_CLEAN, F_TICK: state <= S_PASS;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_STK: state <= S_ALLOC;
        S_ALLOC: begin
          new_idx          <= aidx;
          alloc_q[aidx]    <= 1'b1;
          active_q[aidx]   <= 1'b1;
          expired_q[aidx]  <= 1'b0;
          fc               <= sp;
          if (sp < min_fc) min_fc <= sp;
          res   <= '{kind: K_ALLOC, entry_index: 5'(aidx), wake_channel: 64'd0,
                     last: 1'b1};
          state <= S_PASS;
        end
        S_PASS: begin
          if (adv) begin
            if (issue) rp <= rp + CW'(1);
            if (v2) begin
              if (hit) begin
                active_q[idx2] <= 1'b0;
                if (r.func == F_TICK) expired_q[idx2] <= 1'b1;
                hits   <= hits + 6'd1;
                pend   <= newres;
                pend_v <= 1'b1;
              end else begin
                wp <= wp + CW'(1);
                if (r.func == F_TICK) stopped <= 1'b1;
                if (place) begin
                  ins   <= 1'b1;
                  carry <= idx2;
                end else if (ins) begin
                  carry <= idx2;
                end
              end
            end
          end
          if (done) begin
            cnt   <= wp;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (adv) begin
            if (r.func == F_ALLOC && fin_ins) cnt <= cnt + CW'(1);
            if (push) begin
              fc              <= fc + CW'(1);
              alloc_q[hidx]   <= 1'b0;
              active_q[hidx]  <= 1'b0;
              expired_q[hidx] <= 1'b0;
            end
            pend_v <= 1'b0;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Testbench for sorted_timeout_event_queue: directed and random requests, a
// behavioral predictor of the pool, free stack and sorted list, in-order result checks.
// Depends on steq_pkg and sorted_timeout_event_queue.
module testbench;
  import steq_pkg::*;

  localparam int NPOOL = 32;
  localparam int CYCLE_LIMIT = 900000;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  sorted_timeout_event_queue #(.POOL_SIZE(NPOOL)) i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  // predictor state
  logic [63:0] pool_wake [NPOOL];
  logic [63:0] pool_chan [NPOOL];
  logic [31:0] pool_thread [NPOOL];
  bit          pool_active [NPOOL];
  bit          pool_expired [NPOOL];
  int          wake_order [NPOOL];
  int          n_active;
  int          free_stk [NPOOL];
  int          n_free;

  rsp_t expected_rsp [$];
  int   errors = 0;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_off = 0;
  int   hold_ack = 0;
  int   hold_seq = 0;
  int   hold_len = 0;
  int   cycle_count = 0;
  logic [63:0] chan_pool [4];
  logic [31:0] thread_pool [4];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic void push_result(ref rsp_t res[$], input logic [2:0] k, input int idx,
                                      input logic [63:0] ch);
    rsp_t r;
    r.kind = k;
    r.entry_index = idx[4:0];
    r.wake_channel = ch;
    r.last = 1'b0;
    res.push_back(r);
  endfunction

  function automatic int unlink_pos(int pos);
    int idx;
    idx = wake_order[pos];
    for (int q = pos; q + 1 < n_active; q++) wake_order[q] = wake_order[q + 1];
    n_active--;
    pool_active[idx] = 0;
    return idx;
  endfunction

  function automatic void predict_queue(req_t r);
    rsp_t res[$];
    int idx, pos, p;
    bit on_free, hit;
    case (r.func)
      F_ALLOC: begin
        if (n_free == 0 || n_active >= NPOOL) begin
          push_result(res, K_FULL, 0, 64'd0);
        end else begin
          n_free--;
          idx = free_stk[n_free];
          pool_thread[idx] = r.thread_id;
          pool_chan[idx] = r.channel;
          pool_wake[idx] = r.wake_time;
          pool_active[idx] = 1;
          pool_expired[idx] = 0;
          pos = n_active;
          if (r.wake_time != 0) begin
            for (int q = 0; q < n_active; q++) begin
              if (pool_wake[wake_order[q]] == 0 || pool_wake[wake_order[q]] > r.wake_time) begin
                pos = q;
                break;
              end
            end
          end
          for (int q = n_active; q > pos; q--) wake_order[q] = wake_order[q - 1];
          wake_order[pos] = idx;
          n_active++;
          push_result(res, K_ALLOC, idx, 64'd0);
        end
      end
      F_REL: begin
        idx = int'(r.handle);
        on_free = 0;
        for (int i = 0; i < n_free; i++) if (free_stk[i] == idx) on_free = 1;
        if (!on_free && n_free < NPOOL) begin
          if (pool_active[idx]) begin
            for (int q = 0; q < n_active; q++) begin
              if (wake_order[q] == idx) begin
                void'(unlink_pos(q));
                break;
              end
            end
          end
          push_result(res, pool_expired[idx] ? K_REL_TIMEOUT : K_REL_OK, idx, 64'd0);
          pool_expired[idx] = 0;
          pool_thread[idx] = '0;
          pool_chan[idx] = '0;
          pool_wake[idx] = '0;
          free_stk[n_free] = idx;
          n_free++;
        end
      end
      F_WAKE, F_CLEAN: begin
        p = 0;
        while (p < n_active && res.size() < 32) begin
          idx = wake_order[p];
          hit = (r.func == F_WAKE) ? (pool_chan[idx] == r.channel)
                                   : (pool_thread[idx] == r.thread_id);
          if (hit) begin
            void'(unlink_pos(p));
            if (r.func == F_WAKE) push_result(res, K_WOKEN, idx, pool_chan[idx]);
            else push_result(res, K_CLEANED, idx, 64'd0);
          end else begin
            p++;
          end
        end
        if (res.size() == 0) push_result(res, K_NONE, 0, 64'd0);
      end
      F_TICK: begin
        while (n_active > 0 && res.size() < 32) begin
          idx = wake_order[0];
          if (pool_wake[idx] == 0 || pool_wake[idx] > r.now_time) break;
          void'(unlink_pos(0));
          pool_expired[idx] = 1;
          push_result(res, K_EXPIRED, idx, pool_chan[idx]);
        end
        if (res.size() == 0) push_result(res, K_NONE, 0, 64'd0);
      end
      default: ;
    endcase
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) expected_rsp.push_back(res[i]);
  endfunction

  // result checker
  always @(posedge clk) begin
    rsp_t e;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsp.size() == 0) begin
        $error("unexpected result kind=%0d index=%0d", rsp.kind, rsp.entry_index);
        errors++;
      end else begin
        e = expected_rsp.pop_front();
        if (rsp.kind !== e.kind) begin
          $error("kind: expected %0d actual %0d", e.kind, rsp.kind);
          errors++;
        end
        if (rsp.entry_index !== e.entry_index) begin
          $error("entry_index: expected %0d actual %0d", e.entry_index, rsp.entry_index);
          errors++;
        end
        if (rsp.wake_channel !== e.wake_channel) begin
          $error("wake_channel: expected %h actual %h", e.wake_channel, rsp.wake_channel);
          errors++;
        end
        if (rsp.last !== e.last) begin
          $error("last: expected %0d actual %0d", e.last, rsp.last);
          errors++;
        end
      end
    end
  end

  // receiver stall, with a long hold-off started by bumping hold_seq
  always @(negedge clk) begin
    if (hold_ack != hold_seq) begin
      hold_ack <= hold_seq;
      hold_off <= hold_len - 1;
      rsp_ready <= 1'b0;
    end else if (hold_off > 0) begin
      rsp_ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // valid stays high across back-to-back requests; dropped only while idling
  task automatic send_request(req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predict_queue(r);
    @(negedge clk);
  endtask

  function automatic req_t make_req(logic [2:0] f);
    req_t r;
    r.func = f;
    r.thread_id = {$urandom};
    r.channel = {$urandom, $urandom};
    r.wake_time = {$urandom, $urandom};
    r.handle = 5'($urandom_range(31));
    r.now_time = {$urandom, $urandom};
    return r;
  endfunction

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic test_directed();
    req_t r;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    r = make_req(F_TICK); r.now_time = '1; send_request(r);
    r = make_req(F_WAKE); send_request(r);
    r = make_req(F_CLEAN); send_request(r);
    r = make_req(F_REL); r.handle = 5'd31; send_request(r);
    r = make_req(3'd5); send_request(r);
    r = make_req(3'd7); send_request(r);
    r = make_req(F_ALLOC); r.wake_time = '1; r.channel = '1; r.thread_id = '1; send_request(r);
    r = make_req(F_ALLOC); r.wake_time = 64'd0; r.channel = '0; r.thread_id = '0;
    send_request(r);
    r = make_req(F_ALLOC); r.wake_time = 64'd1; r.channel = '0; send_request(r);
    r = make_req(F_ALLOC); r.wake_time = 64'd1; r.channel = 64'd9; send_request(r);
    r = make_req(F_TICK); r.now_time = 64'd0; send_request(r);
    r = make_req(F_TICK); r.now_time = 64'd1; send_request(r);
    r = make_req(F_REL); r.handle = 5'd2; send_request(r);
    r = make_req(F_REL); r.handle = 5'd0; send_request(r);
    r = make_req(F_WAKE); r.channel = '0; send_request(r);
    r = make_req(F_CLEAN); r.thread_id = '1; send_request(r);
    r = make_req(F_REL); r.handle = 5'd3; send_request(r);
    wait_drained();
  endtask

  // fill the pool; stalled receiver forces backpressure on requests
  task automatic test_full_pool();
    req_t r;
    send_idle_pct = 0;
    hold_len = 300;
    hold_seq++;
    for (int i = 0; i < 34; i++) begin
      r = make_req(F_ALLOC);
      r.wake_time = (i % 5 == 0) ? 64'd0 : 64'd100;
      r.channel = 64'hABC;
      r.thread_id = 32'd7;
      send_request(r);
    end
    r = make_req(F_TICK); r.now_time = 64'd100; send_request(r);
    r = make_req(F_WAKE); r.channel = 64'hABC; send_request(r);
    for (int i = 0; i < 32; i++) begin
      r = make_req(F_REL); r.handle = 5'(i); send_request(r);
    end
    wait_drained();
  endtask

  task automatic test_random(int n, int idle, int stall);
    req_t r;
    int f;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      f = $urandom_range(99);
      if (f < 35) r = make_req(F_ALLOC);
      else if (f < 55) r = make_req(F_REL);
      else if (f < 68) r = make_req(F_WAKE);
      else if (f < 78) r = make_req(F_CLEAN);
      else if (f < 97) r = make_req(F_TICK);
      else r = make_req(3'(5 + $urandom_range(2)));
      if ($urandom_range(3) != 0) begin
        r.channel = chan_pool[$urandom_range(3)];
        r.thread_id = thread_pool[$urandom_range(3)];
        r.wake_time = ($urandom_range(9) == 0) ? 64'd0 : 64'd1000 + $urandom_range(500);
        r.now_time = 64'd900 + $urandom_range(700);
      end
      send_request(r);
    end
    wait_drained();
  endtask

  initial begin
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    for (int i = 0; i < NPOOL; i++) begin
      pool_active[i] = 0;
      pool_expired[i] = 0;
      free_stk[i] = NPOOL - 1 - i;
      pool_wake[i] = '0;
      pool_chan[i] = '0;
      pool_thread[i] = '0;
      wake_order[i] = 0;
    end
    n_active = 0;
    n_free = NPOOL;
    for (int i = 0; i < 4; i++) begin
      chan_pool[i] = {$urandom, $urandom};
      thread_pool[i] = $urandom;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_pool();
    test_random(100, 0, 0);
    test_random(95, 59, 0);
    test_random(95, 0, 59);
    test_random(95, 8, 8);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/steq_pkg.sv
src/sorted_timeout_event_queue.sv
tb/testbench.sv
